>>> rtl/core/mouse_protocol_responder_macros.svh
// Assertion macros shared by the mouse protocol responder RTL.
`ifndef MOUSE_PROTOCOL_RESPONDER_MACROS_SVH
`define MOUSE_PROTOCOL_RESPONDER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mouse responder check failed");

// Next-cycle implication, disabled during reset.
`define MPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mouse responder check failed");

`endif

>>> rtl/core/mpr_pkg.sv
// Types, command codes and reply constants for the mouse protocol responder.
package mpr_pkg;

  // Parameter awaited after a set command
  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_RATE = 2'd1,
    PEND_MODE = 2'd2,
    PEND_RES  = 2'd3
  } pend_t;

  // Host commands
  localparam logic [7:0] CMD_RESET       = 8'h01;
  localparam logic [7:0] CMD_READ_CONFIG = 8'h06;
  localparam logic [7:0] CMD_ENABLE      = 8'h08;
  localparam logic [7:0] CMD_DISABLE     = 8'h09;
  localparam logic [7:0] CMD_WRAP_ON     = 8'h0E;
  localparam logic [7:0] CMD_WRAP_OFF    = 8'h0F;
  localparam logic [7:0] CMD_LINEAR      = 8'h6C;
  localparam logic [7:0] CMD_READ_STATUS = 8'h73;
  localparam logic [7:0] CMD_EXP         = 8'h78;
  localparam logic [7:0] CMD_SET_RES     = 8'h89;
  localparam logic [7:0] CMD_SET_RATE    = 8'h8A;
  localparam logic [7:0] CMD_SET_MODE    = 8'h8D;

  // Reply bytes
  localparam logic [7:0] REPORT_ID     = 8'h0B;
  localparam logic [7:0] STATUS_ID     = 8'h61;
  localparam logic [7:0] RESET_ID      = 8'hFF;
  localparam logic [7:0] RESET_TYPE    = 8'h08;
  localparam logic [7:0] CONFIG_ID     = 8'h20;
  localparam logic [7:0] FLAGS_BASE    = 8'h04;
  localparam logic [7:0] MODE_ARG_REMOTE = 8'h03;

  // Reset values of rate and resolution
  localparam logic [7:0] RESET_RES  = 8'd100;
  localparam logic [7:0] RESET_RATE = 8'd100;

  localparam int unsigned REPLY_LEN = 4;
  localparam logic [1:0]  LAST_IDX  = 2'(REPLY_LEN - 1);

  typedef struct packed {
    logic              kind;
    logic [7:0]        command_byte;
    logic [2:0]        buttons;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       last_byte;
  } out_item_t;

  typedef struct packed {
    pend_t      pending_param;
    logic       reports_enabled;
    logic       exp_scaling;
    logic       remote_mode;
    logic [7:0] resolution_value;
    logic [7:0] rate_value;
  } mouse_state_t;

  // Decode result for one request: next settings and optional reply
  typedef struct packed {
    mouse_state_t              state;
    logic                      reply;
    logic [REPLY_LEN-1:0][7:0] bytes;
  } decode_t;

endpackage

>>> rtl/core/mpr_decode.sv
// Command and motion decode: next mouse settings and the four-byte reply.
module mpr_decode
  import mpr_pkg::*;
(
  input  in_item_t     item,
  input  mouse_state_t cur,
  output decode_t      dec
);

  logic [7:0] flags;
  logic [7:0] motion_status;

  // Build the status flags and the motion status byte
  always_comb begin
    flags = FLAGS_BASE
          | (cur.reports_enabled ? 8'h00 : 8'h20)
          | (cur.exp_scaling     ? 8'h10 : 8'h00)
          | (cur.remote_mode     ? 8'h08 : 8'h00);
    motion_status = {item.buttons[1], item.buttons[2], item.buttons[0], 2'b00,
                     item.delta_x[7], item.delta_y[7], 1'b0};
  end

  // Decode the request
  always_comb begin
    dec       = '0;
    dec.state = cur;
    if (item.kind) begin
      // Motion report: send only while enabled, pending parameter kept
      if (cur.reports_enabled) begin
        dec.reply = 1'b1;
        dec.bytes = {item.delta_y, item.delta_x, motion_status, REPORT_ID};
      end
    end else begin
      dec.state.pending_param = PEND_NONE;
      case (item.command_byte)
        CMD_RESET: begin
          dec.state.reports_enabled = 1'b0;
          dec.reply = 1'b1;
          dec.bytes = {8'h00, 8'h00, RESET_TYPE, RESET_ID};
        end
        CMD_READ_CONFIG: begin
          dec.reply = 1'b1;
          dec.bytes = {8'h00, 8'h00, 8'h00, CONFIG_ID};
        end
        CMD_READ_STATUS: begin
          dec.reply = 1'b1;
          dec.bytes = {cur.rate_value, cur.resolution_value, flags, STATUS_ID};
        end
        CMD_ENABLE:   dec.state.reports_enabled = 1'b1;
        CMD_DISABLE:  dec.state.reports_enabled = 1'b0;
        CMD_WRAP_ON,
        CMD_WRAP_OFF: dec.state.pending_param = PEND_NONE;
        CMD_EXP:      dec.state.exp_scaling = 1'b1;
        CMD_LINEAR:   dec.state.exp_scaling = 1'b0;
        CMD_SET_RATE: dec.state.pending_param = PEND_RATE;
        CMD_SET_MODE: dec.state.pending_param = PEND_MODE;
        CMD_SET_RES:  dec.state.pending_param = PEND_RES;
        default: begin
          // Parameter byte for an earlier set command
          case (cur.pending_param)
            PEND_RATE: dec.state.rate_value = item.command_byte;
            PEND_MODE: dec.state.remote_mode = (item.command_byte == MODE_ARG_REMOTE);
            PEND_RES:  dec.state.resolution_value = item.command_byte;
            default:   dec.state.pending_param = PEND_NONE;
          endcase
        end
      endcase
    end
  end

endmodule

>>> rtl/core/mouse_protocol_responder.sv
// Mouse protocol responder top level: settings, reply buffer and byte output.
// The first reply byte is offered in the cycle after its request is accepted.
// A reply's four bytes leave the output one byte per cycle while out_stall is low.
// Requests that give no reply are accepted every cycle, also while a reply drains.
// A replying request is taken in the cycle the previous reply's last byte leaves.
// Synchronous active-low reset restores default settings and empties the buffer.
`include "mouse_protocol_responder_macros.svh"
module mouse_protocol_responder
  import mpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  mouse_state_t              state_r;
  decode_t                   dec;
  logic [REPLY_LEN-1:0][7:0] reply_r;
  logic [1:0]                idx_r;
  logic                      busy_r;
  logic                      out_take;
  logic                      last_take;
  logic                      in_take;

  mpr_decode u_decode (
    .item (in_data),
    .cur  (state_r),
    .dec  (dec)
  );

  // Hold back only replying requests while a reply is still draining
  always_comb begin
    out_take  = busy_r && !out_stall;
    last_take = out_take && (idx_r == LAST_IDX);
    in_stall  = busy_r && !last_take && dec.reply;
    in_take   = in_valid && !in_stall;
  end

  // Advance settings on every accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.pending_param    <= PEND_NONE;
      state_r.reports_enabled  <= 1'b1;
      state_r.exp_scaling      <= 1'b0;
      state_r.remote_mode      <= 1'b0;
      state_r.resolution_value <= RESET_RES;
      state_r.rate_value       <= RESET_RATE;
    end else if (in_take) begin
      state_r <= dec.state;
    end
  end

  // Load the reply buffer and step through its bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (in_take && dec.reply) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (out_take) begin
      if (idx_r == LAST_IDX) begin
        busy_r <= 1'b0;
      end
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && dec.reply) begin
      reply_r <= dec.bytes;
    end
  end

  // Drive the current byte
  always_comb begin
    out_valid           = busy_r;
    out_data.reply_byte = reply_r[idx_r];
    out_data.last_byte  = (idx_r == LAST_IDX);
  end

  `MPR_ASSERT_NEXT(a_reply_starts, clk, rst_n, in_take && dec.reply, busy_r && (idx_r == '0))
  `MPR_ASSERT_NOW(a_no_overwrite, clk, rst_n, in_take && dec.reply && busy_r, last_take)
  `MPR_ASSERT_NEXT(a_drain_ends, clk, rst_n, last_take && !(in_take && dec.reply), !busy_r)
  `MPR_ASSERT_NEXT(a_stall_holds, clk, rst_n, busy_r && out_stall, busy_r && $stable(idx_r))

endmodule

>>> verif/mouse_protocol_responder_tb.sv
// Self-checking testbench for the mouse protocol responder: directed and random requests.
module mouse_protocol_responder_tb;
  import mpr_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 10;

  // Bits of the motion status byte
  localparam logic [7:0] STAT_LEFT   = 8'h20;
  localparam logic [7:0] STAT_RIGHT  = 8'h80;
  localparam logic [7:0] STAT_MIDDLE = 8'h40;
  localparam logic [7:0] STAT_X_NEG  = 8'h04;
  localparam logic [7:0] STAT_Y_NEG  = 8'h02;

  // Bits of the read-status flags byte
  localparam logic [7:0] FLAG_DISABLED = 8'h20;
  localparam logic [7:0] FLAG_EXP      = 8'h10;
  localparam logic [7:0] FLAG_REMOTE   = 8'h08;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  out_item_t expected_bytes[$];
  int        failures = 0;
  int        cycles = 0;
  int        stall_left = 0;
  bit        idle_on = 1'b1;

  // Mouse settings as the host should see them
  pend_t      awaited = PEND_NONE;
  bit         reports_on = 1'b1;
  bit         exp_on = 1'b0;
  bit         remote_on = 1'b0;
  logic [7:0] res_now = RESET_RES;
  logic [7:0] rate_now = RESET_RATE;

  mouse_protocol_responder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Queue the four bytes of one reply, marking the last
  task automatic queue_reply(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3);
    expected_bytes.push_back('{reply_byte: b0, last_byte: 1'b0});
    expected_bytes.push_back('{reply_byte: b1, last_byte: 1'b0});
    expected_bytes.push_back('{reply_byte: b2, last_byte: 1'b0});
    expected_bytes.push_back('{reply_byte: b3, last_byte: 1'b1});
  endtask

  // Update the settings for one accepted request and queue its reply
  task automatic predict_reply(input in_item_t req);
    logic [7:0] st;
    if (req.kind) begin
      if (!reports_on) return;
      st = 8'h00;
      if (req.buttons[0]) st |= STAT_LEFT;
      if (req.buttons[1]) st |= STAT_RIGHT;
      if (req.buttons[2]) st |= STAT_MIDDLE;
      if (req.delta_x[7]) st |= STAT_X_NEG;
      if (req.delta_y[7]) st |= STAT_Y_NEG;
      queue_reply(REPORT_ID, st, req.delta_x, req.delta_y);
      return;
    end
    case (req.command_byte)
      CMD_RESET: begin
        reports_on = 1'b0;
        awaited = PEND_NONE;
        queue_reply(RESET_ID, RESET_TYPE, 8'h00, 8'h00);
      end
      CMD_READ_CONFIG: begin
        awaited = PEND_NONE;
        queue_reply(CONFIG_ID, 8'h00, 8'h00, 8'h00);
      end
      CMD_READ_STATUS: begin
        st = FLAGS_BASE;
        if (!reports_on) st |= FLAG_DISABLED;
        if (exp_on) st |= FLAG_EXP;
        if (remote_on) st |= FLAG_REMOTE;
        awaited = PEND_NONE;
        queue_reply(STATUS_ID, st, res_now, rate_now);
      end
      CMD_ENABLE: begin
        reports_on = 1'b1;
        awaited = PEND_NONE;
      end
      CMD_DISABLE: begin
        reports_on = 1'b0;
        awaited = PEND_NONE;
      end
      CMD_WRAP_ON, CMD_WRAP_OFF: awaited = PEND_NONE;
      CMD_EXP: begin
        exp_on = 1'b1;
        awaited = PEND_NONE;
      end
      CMD_LINEAR: begin
        exp_on = 1'b0;
        awaited = PEND_NONE;
      end
      CMD_SET_RATE: awaited = PEND_RATE;
      CMD_SET_MODE: awaited = PEND_MODE;
      CMD_SET_RES:  awaited = PEND_RES;
      default: begin
        // any other byte is the parameter of a pending set command
        case (awaited)
          PEND_RATE: rate_now = req.command_byte;
          PEND_MODE: remote_on = (req.command_byte == MODE_ARG_REMOTE);
          PEND_RES:  res_now = req.command_byte;
          default: ;
        endcase
        awaited = PEND_NONE;
      end
    endcase
  endtask

  function automatic in_item_t host_byte(input logic [7:0] code);
    in_item_t req;
    req.kind = 1'b0;
    req.command_byte = code;
    req.buttons = 3'($urandom_range(0, 7));
    req.delta_x = 8'($urandom_range(0, 255));
    req.delta_y = 8'($urandom_range(0, 255));
    return req;
  endfunction

  function automatic in_item_t motion(input logic [2:0] btn, input logic [7:0] dx,
                                      input logic [7:0] dy);
    in_item_t req;
    req.kind = 1'b1;
    req.command_byte = 8'($urandom_range(0, 255));
    req.buttons = btn;
    req.delta_x = dx;
    req.delta_y = dy;
    return req;
  endfunction

  function automatic logic [7:0] any_command(input int idx);
    case (idx)
      0:  return CMD_RESET;
      1:  return CMD_READ_CONFIG;
      2:  return CMD_ENABLE;
      3:  return CMD_DISABLE;
      4:  return CMD_WRAP_ON;
      5:  return CMD_WRAP_OFF;
      6:  return CMD_LINEAR;
      7:  return CMD_READ_STATUS;
      8:  return CMD_EXP;
      9:  return CMD_SET_RES;
      10: return CMD_SET_RATE;
      default: return CMD_SET_MODE;
    endcase
  endfunction

  // Offer one request after a random gap and hold it until accepted
  task automatic send_request(input in_item_t req);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_reply(req);
  endtask

  // Drop valid and hold off until every queued reply byte has left
  task automatic wait_for_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic test_power_on_state();
    send_request(host_byte(CMD_READ_STATUS));
  endtask

  // Extreme deltas and every button bit both ways
  task automatic test_motion_fields();
    send_request(motion(3'd1, 8'h7F, 8'h80));
    send_request(motion(3'd6, 8'h80, 8'h7F));
  endtask

  task automatic test_host_commands();
    send_request(host_byte(CMD_WRAP_ON));
    send_request(host_byte(CMD_WRAP_OFF));
    send_request(host_byte(CMD_EXP));
    send_request(host_byte(CMD_SET_MODE));
    send_request(host_byte(MODE_ARG_REMOTE));
    send_request(host_byte(CMD_READ_STATUS));
    send_request(host_byte(CMD_DISABLE));
    // motion while disabled is dropped
    send_request(motion(3'd7, 8'hFF, 8'h01));
    send_request(host_byte(CMD_LINEAR));
    send_request(host_byte(CMD_SET_MODE));
    send_request(host_byte(8'h00));
    send_request(host_byte(CMD_ENABLE));
  endtask

  task automatic test_parameters();
    send_request(host_byte(CMD_SET_RATE));
    // motion between command and parameter keeps the parameter pending
    send_request(motion(3'd0, 8'h00, 8'hFF));
    send_request(host_byte(8'hFF));
    send_request(host_byte(CMD_SET_RES));
    // the report id byte is not a command, so it is a parameter
    send_request(host_byte(REPORT_ID));
    send_request(host_byte(CMD_SET_RATE));
    send_request(host_byte(CMD_READ_CONFIG));
    // nothing pending any more: ignored
    send_request(host_byte(8'h55));
    send_request(host_byte(CMD_READ_STATUS));
    send_request(host_byte(CMD_RESET));
    send_request(host_byte(CMD_READ_STATUS));
    send_request(host_byte(CMD_ENABLE));
  endtask

  task automatic test_random_traffic();
    int sent;
    int chunk;
    int pick;
    logic [7:0] set_cmd;
    logic [7:0] arg;
    sent = 0;
    for (chunk = 0; chunk < 4; chunk++) begin
      // run the third stretch back to back on both sides
      idle_on = (chunk != 2);
      while (sent < (chunk + 1) * RANDOM_ITEMS / 4) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          send_request(motion(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255))));
          sent++;
        end else if (pick < 65) begin
          case ($urandom_range(0, 2))
            0:       set_cmd = CMD_SET_RATE;
            1:       set_cmd = CMD_SET_MODE;
            default: set_cmd = CMD_SET_RES;
          endcase
          send_request(host_byte(set_cmd));
          sent++;
          if ($urandom_range(0, 7) == 0) begin
            send_request(motion(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255))));
            sent++;
          end
          // mostly a real parameter, sometimes a command that breaks the sequence
          if ($urandom_range(0, 9) == 0) arg = any_command($urandom_range(0, 11));
          else if (set_cmd == CMD_SET_MODE && $urandom_range(0, 1) == 1)
            arg = MODE_ARG_REMOTE;
          else arg = 8'($urandom_range(0, 255));
          send_request(host_byte(arg));
          sent++;
          if ($urandom_range(0, 2) == 0) begin
            send_request(host_byte(CMD_READ_STATUS));
            sent++;
          end
        end else if (pick < 85) begin
          // favor enable so that motion reports keep flowing
          if ($urandom_range(0, 2) == 0) send_request(host_byte(CMD_ENABLE));
          else send_request(host_byte(any_command($urandom_range(0, 11))));
          sent++;
        end else begin
          send_request(host_byte(8'($urandom_range(0, 255))));
          sent++;
        end
      end
      wait_for_replies();
    end
    idle_on = 1'b1;
  endtask

  // Stall the result side for a random number of cycles after each byte taken
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      stall_left = idle_on ? $urandom_range(0, 9) : 0;
    end else if (stall_left != 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  // Compare each accepted reply byte with the oldest expectation
  always @(posedge clk) begin : check_replies
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected reply byte %h (last_byte %b)", out_data.reply_byte,
               out_data.last_byte);
        failures++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_data.reply_byte !== want.reply_byte) begin
          $error("reply_byte: expected %h, got %h", want.reply_byte, out_data.reply_byte);
          failures++;
        end
        if (out_data.last_byte !== want.last_byte) begin
          $error("last_byte: expected %b, got %b", want.last_byte, out_data.last_byte);
          failures++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_power_on_state();
    wait_for_replies();
    test_motion_fields();
    wait_for_replies();
    test_host_commands();
    wait_for_replies();
    test_parameters();
    wait_for_replies();
    test_random_traffic();
    wait_for_replies();
    if (expected_bytes.size() != 0) begin
      $error("%0d reply bytes never arrived", expected_bytes.size());
      failures++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

>>> mouse_protocol_responder.f
+incdir+rtl/core
rtl/core/mpr_pkg.sv
rtl/core/mpr_decode.sv
rtl/core/mouse_protocol_responder.sv
verif/mouse_protocol_responder_tb.sv
